// ----- src/bf3m_pkg.sv -----
// Shared types and constants for the 3x3 box mean filter.
// Used by the front, back and top modules; no dependencies.
package bf3m_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int FRAC_BITS  = 8;
	localparam int CNT_W      = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam int RESET_DIM = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             emit;
		logic             last;
		logic             wr_en;
		logic             use_above;
		logic             use_two;
		logic             add_s;
		logic             add_cs1;
		logic [CNT_W-1:0] count;
	} item_ctl_t;

	localparam int CTL_W = $bits(item_ctl_t);

endpackage

// ----- src/bf3m_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf3m_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/bf3m_fifo.sv -----
// Short beat queue between the front and the back of the filter.
// No dependencies.
module bf3m_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/bf3m_front.sv -----
// Front end: frame geometry registers, raster position and beat classification.
// Depends on bf3m_pkg.
module bf3m_front #(
	parameter int MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bf3m_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = bf3m_pkg::DEF_PIXEL_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bf3m_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bf3m_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            q_full,
	input  logic                            cmd,
	input  logic [PIXEL_BITS-1:0]           pixel,
	output logic                            push,
	output bf3m_pkg::item_ctl_t             push_ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]    push_addr,
	output logic [PIXEL_BITS-1:0]           push_pix
);

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT + 2);
	localparam int RST_W = (MAX_WIDTH < bf3m_pkg::RESET_DIM) ? MAX_WIDTH : bf3m_pkg::RESET_DIM;
	localparam int RST_H = (MAX_HEIGHT < bf3m_pkg::RESET_DIM) ? MAX_HEIGHT : bf3m_pkg::RESET_DIM;

	logic [WB-1:0] width_q;
	logic [RB-1:0] height_q;
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	logic [WB-1:0] width_new;
	logic [RB-1:0] height_new;
	logic          col_zero;
	logic          row_end;
	logic          in_frame;
	logic [1:0]    rows;
	logic [1:0]    cols;

	assign push = in_valid && !q_full;

	always_comb begin
		if (cfg_wdata == '0) begin
			width_new  = WB'(1);
			height_new = RB'(1);
		end else begin
			width_new  = (32'(cfg_wdata) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(cfg_wdata);
			height_new = (32'(cfg_wdata) > MAX_HEIGHT) ? RB'(MAX_HEIGHT) : RB'(cfg_wdata);
		end
	end

	always_comb begin
		col_zero = (col_q == '0);
		row_end  = ((WB'(col_q) + WB'(1)) >= width_q);
		in_frame = (row_q < height_q);
		push_ctl = '0;
		rows     = 2'd1;
		cols     = 2'd1;
		if (col_zero) begin
			// close the row two rows up from the stored column sums
			push_ctl.emit    = (row_q >= RB'(2));
			push_ctl.last    = (row_q > height_q);
			push_ctl.add_s   = 1'b0;
			push_ctl.add_cs1 = (width_q >= WB'(2));
			rows = 2'd1 + 2'(row_q > RB'(2)) + 2'(row_q <= height_q);
			cols = (width_q >= WB'(2)) ? 2'd2 : 2'd1;
		end else begin
			push_ctl.emit    = (row_q >= RB'(1)) && (row_q <= height_q);
			push_ctl.last    = 1'b0;
			push_ctl.add_s   = 1'b1;
			push_ctl.add_cs1 = (col_q > CB'(1));
			rows = 2'd1 + 2'(row_q > RB'(1)) + 2'(row_q < height_q);
			cols = 2'd2 + 2'(col_q > CB'(1));
		end
		push_ctl.count     = bf3m_pkg::CNT_W'(rows) * bf3m_pkg::CNT_W'(cols);
		push_ctl.wr_en     = in_frame;
		push_ctl.use_above = (row_q >= RB'(1)) && (row_q <= height_q);
		push_ctl.use_two   = (row_q >= RB'(2)) && (row_q <= height_q);
		push_addr          = col_q;
		push_pix           = (in_frame && !cmd) ? pixel : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WB'(RST_W);
			height_q <= RB'(RST_H);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bf3m_pkg::REG_IMAGE_WIDTH: begin
					width_q <= width_new;
				end
				bf3m_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= height_new;
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_q > height_q) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RB'(1);
			end else begin
				col_q <= col_q + CB'(1);
			end
		end
	end

endmodule

// ----- src/bf3m_back.sv -----
// Back end: line buffers, column sums, divide by neighbor count, output register.
// Depends on bf3m_pkg and bf3m_ram.
module bf3m_back #(
	parameter int MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = bf3m_pkg::DEF_PIXEL_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    restart,
	input  logic                                    q_empty,
	input  bf3m_pkg::item_ctl_t                     q_ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0]            q_addr,
	input  logic [PIXEL_BITS-1:0]                   q_pix,
	output logic                                    q_pop,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [PIXEL_BITS+bf3m_pkg::FRAC_BITS-1:0] mean,
	output logic                                    frame_last
);

	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int FB    = bf3m_pkg::FRAC_BITS;
	localparam int CSB   = PIXEL_BITS + 2;
	localparam int SUMB  = PIXEL_BITS + 4;
	localparam int NB    = SUMB + FB;
	localparam int K     = NB + 4;
	localparam int MB    = PIXEL_BITS + FB;
	localparam int PRODB = NB + K + 1;
	localparam logic [63:0] ONE = 64'd1;
	localparam logic [63:0] M1_W = ONE << K;
	localparam logic [63:0] M2_W = ONE << (K - 1);
	localparam logic [63:0] M3_W = ((ONE << K) + 64'd2) / 64'd3;
	localparam logic [63:0] M4_W = ONE << (K - 2);
	localparam logic [63:0] M6_W = ((ONE << K) + 64'd5) / 64'd6;
	localparam logic [63:0] M9_W = ((ONE << K) + 64'd8) / 64'd9;

	logic adv;
	logic wr_now;

	// stage 1: line buffer data present
	logic                      valid_s1;
	bf3m_pkg::item_ctl_t       ctl_s1;
	logic [CB-1:0]             addr_s1;
	logic [PIXEL_BITS-1:0]     pix_s1;
	logic                      fwd_s1;
	logic [PIXEL_BITS-1:0]     fwd_a_s1;
	logic [PIXEL_BITS-1:0]     fwd_b_s1;
	logic [PIXEL_BITS-1:0]     ram_a;
	logic [PIXEL_BITS-1:0]     ram_b;
	logic [PIXEL_BITS-1:0]     above;
	logic [PIXEL_BITS-1:0]     two_above;
	logic [CSB-1:0]            col_sum;
	logic [SUMB-1:0]           win_sum;
	logic [CSB-1:0]            cs0_q;
	logic [CSB-1:0]            cs1_q;

	// stage 2: window sum
	logic                      valid_s2;
	logic [SUMB-1:0]           sum_s2;
	logic [bf3m_pkg::CNT_W-1:0] cnt_s2;
	logic                      last_s2;
	logic [K:0]                recip;

	// stage 3: numerator and reciprocal
	logic                      valid_s3;
	logic [NB-1:0]             num_s3;
	logic [K:0]                recip_s3;
	logic                      last_s3;

	// stage 4: product
	logic                      valid_s4;
	logic [PRODB-1:0]          prod_s4;
	logic                      last_s4;

	logic                      out_valid_q;
	logic [MB-1:0]             mean_q;
	logic                      last_q;

	assign adv    = !out_valid_q || !out_stall;
	assign q_pop  = adv && !q_empty;
	assign wr_now = adv && valid_s1 && ctl_s1.wr_en;

	bf3m_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
		.clk   (clk),
		.we    (wr_now),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (ram_a)
	);

	bf3m_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
		.clk   (clk),
		.we    (wr_now),
		.waddr (addr_s1),
		.wdata (above),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (ram_b)
	);

	always_comb begin
		above     = fwd_s1 ? fwd_a_s1 : ram_a;
		two_above = fwd_s1 ? fwd_b_s1 : ram_b;
		col_sum   = CSB'(pix_s1)
			+ (ctl_s1.use_above ? CSB'(above) : '0)
			+ (ctl_s1.use_two ? CSB'(two_above) : '0);
		win_sum   = SUMB'(cs0_q)
			+ (ctl_s1.add_cs1 ? SUMB'(cs1_q) : '0)
			+ (ctl_s1.add_s ? SUMB'(col_sum) : '0);
	end

	always_comb begin
		case (cnt_s2)
			4'd1:    recip = M1_W[K:0];
			4'd2:    recip = M2_W[K:0];
			4'd3:    recip = M3_W[K:0];
			4'd4:    recip = M4_W[K:0];
			4'd6:    recip = M6_W[K:0];
			4'd9:    recip = M9_W[K:0];
			default: recip = M1_W[K:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			cs0_q       <= '0;
			cs1_q       <= '0;
		end else begin
			if (adv) begin
				valid_s1    <= !q_empty;
				fwd_s1      <= wr_now && (q_addr == addr_s1);
				valid_s2    <= valid_s1 && ctl_s1.emit;
				valid_s3    <= valid_s2;
				valid_s4    <= valid_s3;
				out_valid_q <= valid_s4;
			end
			if (restart) begin
				cs0_q <= '0;
				cs1_q <= '0;
			end else if (adv && valid_s1) begin
				cs1_q <= cs0_q;
				cs0_q <= col_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= q_ctl;
			addr_s1  <= q_addr;
			pix_s1   <= q_pix;
			fwd_a_s1 <= pix_s1;
			fwd_b_s1 <= above;
			sum_s2   <= win_sum;
			cnt_s2   <= ctl_s1.count;
			last_s2  <= ctl_s1.last;
			num_s3   <= {sum_s2, {FB{1'b0}}} + NB'(cnt_s2 >> 1);
			recip_s3 <= recip;
			last_s3  <= last_s2;
			prod_s4  <= PRODB'(num_s3) * PRODB'(recip_s3);
			last_s4  <= last_s3;
			mean_q   <= prod_s4[K +: MB];
			last_q   <= last_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean       = mean_q;
	assign frame_last = last_q;

endmodule

// ----- src/box_filter_3x3_mean_core.sv -----
// Top level of the streaming 3x3 box mean filter.
// Depends on bf3m_pkg, bf3m_front, bf3m_fifo and bf3m_back.
//
// Usage:
//   Pixels enter in raster order on the input channel (in_valid / in_stall,
//   fields cmd and pixel); cmd high marks a drain beat that carries no pixel.
//   Each beat advances the frame position. The mean of raster position q is
//   produced by the beat at position q + image_width + 1, so after a frame's
//   image_width * image_height pixels the source sends image_width + 1 drain
//   beats; frame_last marks the last mean of the frame.
//   Results leave on the output channel (out_valid / out_stall, fields mean
//   in 8.8 fixed point and frame_last). A result is valid once the beat that
//   causes it has passed the queue and the back pipeline registers; one beat
//   is accepted every cycle while the queue is not full.
//   While the receiver stalls, the back pipeline holds and the four-entry
//   queue fills; then in_stall rises until results drain.
//   Register writes (cfg_we, cfg_idx, cfg_wdata) take effect at once and
//   restart the frame; issue them only with the block idle.
//   Reset sets width and height to 1024 (clamped to the maximums), clears the
//   frame position and column sums, and empties the queue and pipeline.
module box_filter_3x3_mean_core #(
	parameter int MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bf3m_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = bf3m_pkg::DEF_PIXEL_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [bf3m_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  logic [bf3m_pkg::CFG_DATA_W-1:0]          cfg_wdata,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     cmd,
	input  logic [PIXEL_BITS-1:0]                    pixel,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [PIXEL_BITS+bf3m_pkg::FRAC_BITS-1:0] mean,
	output logic                                     frame_last
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int QW = bf3m_pkg::CTL_W + CB + PIXEL_BITS;

	logic                  push;
	bf3m_pkg::item_ctl_t   push_ctl;
	logic [CB-1:0]         push_addr;
	logic [PIXEL_BITS-1:0] push_pix;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	logic [QW-1:0]         head;
	bf3m_pkg::item_ctl_t   head_ctl;
	logic [CB-1:0]         head_addr;
	logic [PIXEL_BITS-1:0] head_pix;

	assign in_stall  = q_full;
	assign head_pix  = head[PIXEL_BITS-1:0];
	assign head_addr = head[PIXEL_BITS +: CB];
	assign head_ctl  = bf3m_pkg::item_ctl_t'(head[QW-1 -: bf3m_pkg::CTL_W]);

	bf3m_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.q_full    (q_full),
		.cmd       (cmd),
		.pixel     (pixel),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_addr (push_addr),
		.push_pix  (push_pix)
	);

	bf3m_fifo #(
		.WIDTH (QW),
		.DEPTH (bf3m_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctl, push_addr, push_pix}),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_data (head)
	);

	bf3m_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.q_empty    (q_empty),
		.q_ctl      (head_ctl),
		.q_addr     (head_addr),
		.q_pix      (head_pix),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mean       (mean),
		.frame_last (frame_last)
	);

endmodule
